/* hw/rtl/qls_pkg.sv */
// Shared constants and types of the tabular Q-learning step core.
package qls_pkg;

    localparam int VALUE_W      = 32;  // Q16.16 table entries, reward, updated value
    localparam int FRAC_W       = 16;  // Q0.16 coefficients and random fraction
    localparam int STATE_IDX_W  = 8;
    localparam int ACTION_IDX_W = 3;
    localparam int CFG_IDX_W    = 2;

    localparam int NUM_STATES_DEF  = 256;
    localparam int NUM_ACTIONS_DEF = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_PROB = 2'd2;

    localparam logic [FRAC_W-1:0] LEARN_RATE_RST   = 16'd6554;
    localparam logic [FRAC_W-1:0] DISCOUNT_RST     = 16'd58982;
    localparam logic [FRAC_W-1:0] EXPLORE_PROB_RST = 16'd6554;

    typedef struct packed {
        logic                      start;
        logic [FRAC_W-1:0]         alpha;
        logic [FRAC_W-1:0]         gamma;
        logic signed [VALUE_W-1:0] reward;
        logic signed [VALUE_W-1:0] maxq;
        logic signed [VALUE_W-1:0] oldq;
    } t_upd_req;

    typedef struct packed {
        logic                      done;
        logic                      sat;
        logic signed [VALUE_W-1:0] value;
    } t_upd_rsp;

endpackage

/* hw/rtl/qls_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module qls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/qls_update.sv */
// Four-stage Q update datapath: old + floor(alpha*(r + floor(gamma*maxq) - old)), clamped.
module qls_update
    import qls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_upd_req i_req,
    output t_upd_rsp o_rsp
);

    localparam int VW = VALUE_W;

    // Operands other than start are to be held stable by the caller for the whole pass; this module does not check it.
    logic [3:0] r_vld;

    logic signed [VW+16:0] p1;
    logic signed [VW:0]    r_g;
    logic signed [VW+1:0]  r_d;
    logic signed [VW+18:0] p2;
    logic signed [VW+2:0]  r_t;
    logic signed [VW+3:0]  sum;
    logic [4:0]            sum_top;
    logic                  clip;
    logic                  r_sat;
    logic signed [VW-1:0]  r_value;

    assign p1      = $signed({1'b0, i_req.gamma}) * i_req.maxq;
    assign p2      = $signed({1'b0, i_req.alpha}) * r_d;
    assign sum     = {{4{i_req.oldq[VW-1]}}, i_req.oldq} + {r_t[VW+2], r_t};
    assign sum_top = sum[VW+3:VW-1];
    assign clip    = !((&sum_top) || !(|sum_top));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_req.start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_g <= p1[VW+16:16];                            // floor shift
        r_d <= {{2{i_req.reward[VW-1]}}, i_req.reward} + {r_g[VW], r_g}
               - {{2{i_req.oldq[VW-1]}}, i_req.oldq};
        r_t <= p2[VW+18:16];
        if (r_vld[2]) begin
            r_sat <= clip;
            if (!clip) begin
                r_value <= sum[VW-1:0];
            end else if (sum[VW+3]) begin
                r_value <= {1'b1, {(VW-1){1'b0}}};
            end else begin
                r_value <= {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    assign o_rsp.done  = r_vld[3];
    assign o_rsp.sat   = r_sat;
    assign o_rsp.value = r_value;

endmodule

/* hw/rtl/tabular_q_learning_step_core.sv */
// Top level of the tabular Q-learning step core with epsilon-greedy action choice.
//
// The Q table (NUM_STATES x NUM_ACTIONS signed Q16.16 entries) lives in one RAM with a
// single write port and a single registered read port; each row is swept through that
// read port. After reset the core zeroes the table, one entry per cycle, and stalls
// input items meanwhile (configuration writes are taken at any time). A start item goes
// straight to the done state. A learn item runs through one read of Q(prev), a sweep
// of the new state's row for the max and argmax, the four-stage update pipeline, and
// the write-back. When the new state equals the previous state the row is swept a
// second time after the write to get the argmax from the updated values. One item
// is in flight at a time; a finished result waits in the output register, so the next
// item is accepted while the result is still stalled downstream.
module tabular_q_learning_step_core
    import qls_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_op,
    input  logic [STATE_IDX_W-1:0]  i_state_index,
    input  logic [ACTION_IDX_W-1:0] i_start_action,
    input  logic signed [VALUE_W-1:0] i_reward,
    input  logic [FRAC_W-1:0]       i_rand_fraction,
    input  logic [ACTION_IDX_W-1:0] i_rand_action,
    // result items
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ACTION_IDX_W-1:0] o_chosen_action,
    output logic                    o_explored,
    output logic signed [VALUE_W-1:0] o_updated_value,
    output logic                    o_saturated,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [FRAC_W-1:0]       i_cfg_data
);

    localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(NUM_STATES);
    localparam int ACW   = $clog2(NUM_ACTIONS);

    localparam logic [2:0] S_CLEAR = 3'd0;  // zeroing sweep after reset
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_OLD   = 3'd2;  // read Q(prev)
    localparam logic [2:0] S_ROW1  = 3'd3;  // sweep new row before the write
    localparam logic [2:0] S_CALC  = 3'd4;  // update pipeline
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_ROW2  = 3'd6;  // re-sweep when the written row is the new row
    localparam logic [2:0] S_DONE  = 3'd7;

    // x mod m by restoring subtraction, eight steps on an 8-bit value
    function automatic logic [7:0] mod_by(input logic [7:0] x, input int unsigned m);
        logic [7:0]  rem;
        int unsigned sh;
        rem = x;
        for (int k = 7; k >= 0; k--) begin
            sh = m << k;
            if (sh <= 32'd255 && 32'(rem) >= sh) begin
                rem = rem - sh[7:0];
            end
        end
        return rem;
    endfunction

    logic [2:0] r_state, n_state;

    logic [FRAC_W-1:0] r_learn_rate, r_discount, r_explore_prob;

    logic [SW-1:0]  r_prev_state;
    logic [ACW-1:0] r_prev_action;

    // latched item
    logic                      r_op;
    logic [SW-1:0]             r_s;
    logic [ACW-1:0]            r_sa;
    logic [ACW-1:0]            r_ra;
    logic signed [VALUE_W-1:0] r_reward;
    logic [FRAC_W-1:0]         r_rf;
    logic [AW-1:0]             r_row_base;
    logic [AW-1:0]             r_pidx;

    // row sweep
    logic                      r_issuing;
    logic [ACW-1:0]            r_issue;
    logic                      r_tag_vld;
    logic [ACW-1:0]            r_tag_idx;
    logic                      r_old_pend;
    logic signed [VALUE_W-1:0] r_oldq;
    logic signed [VALUE_W-1:0] r_best_val;
    logic [ACW-1:0]            r_best_idx;
    logic                      take;
    logic                      last_tag;
    logic                      in_row;

    // update
    logic                      r_upd_start;
    logic signed [VALUE_W-1:0] r_new;
    logic                      r_sat;
    t_upd_req                  upd_req;
    t_upd_rsp                  upd_rsp;

    // memory ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic [AW-1:0]      r_clr_addr;

    // output register
    logic                      r_out_valid;
    logic [ACTION_IDX_W-1:0]   r_out_action;
    logic                      r_out_explored;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_sat;

    logic in_acc;
    logic out_free;
    logic explore_now;
    logic [ACW-1:0] s_act;
    logic [SW-1:0]  s_mod;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_row   = r_state inside {S_ROW1, S_ROW2};
    assign take     = (r_tag_idx == '0) || ($signed(mem_rdata) > r_best_val);
    assign last_tag = r_tag_vld && (r_tag_idx == ACW'(NUM_ACTIONS - 1));
    assign s_mod    = SW'(mod_by(i_state_index, NUM_STATES));

    // exploration needs a nonzero epsilon and a fraction below it
    assign explore_now = (r_explore_prob != '0) && (r_rf < r_explore_prob);
    assign s_act       = r_op ? (explore_now ? r_ra : r_best_idx) : r_sa;

    // ---------------------------------------------------------------- configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate   <= LEARN_RATE_RST;
            r_discount     <= DISCOUNT_RST;
            r_explore_prob <= EXPLORE_PROB_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                CFG_DISCOUNT:     r_discount     <= i_cfg_data;
                CFG_EXPLORE_PROB: r_explore_prob <= i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = i_op ? S_OLD : S_DONE;
            S_OLD:   n_state = S_ROW1;
            S_ROW1:  if (last_tag) n_state = S_CALC;
            S_CALC:  if (upd_rsp.done) n_state = S_WRITE;
            // argmax of the first sweep stands unless the write landed in this row
            S_WRITE: n_state = (r_prev_state == r_s) ? S_ROW2 : S_DONE;
            S_ROW2:  if (last_tag) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_prev_state  <= '0;
            r_prev_action <= '0;
            r_issuing     <= 1'b0;
            r_tag_vld     <= 1'b0;
            r_old_pend    <= 1'b0;
            r_upd_start   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_old_pend  <= (r_state == S_OLD);
            r_tag_vld   <= in_row && r_issuing;
            r_upd_start <= (r_state == S_ROW1) && last_tag;

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end

            // row read issue: one address per cycle
            if (r_state == S_OLD || r_state == S_WRITE) begin
                r_issuing <= (n_state == S_ROW1) || (n_state == S_ROW2);
            end else if (in_row && r_issuing && r_issue == ACW'(NUM_ACTIONS - 1)) begin
                r_issuing <= 1'b0;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid   <= 1'b1;
                r_prev_state  <= r_s;
                r_prev_action <= s_act;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_op;
            r_s        <= s_mod;
            r_sa       <= ACW'(mod_by(8'(i_start_action), NUM_ACTIONS));
            r_ra       <= ACW'(mod_by(8'(i_rand_action), NUM_ACTIONS));
            r_reward   <= i_reward;
            r_rf       <= i_rand_fraction;
            r_row_base <= AW'(32'(s_mod) * NUM_ACTIONS);
            r_pidx     <= AW'(32'(r_prev_state) * NUM_ACTIONS + 32'(r_prev_action));
        end

        if (r_state == S_OLD || r_state == S_WRITE) begin
            r_issue <= '0;
        end else if (in_row && r_issuing) begin
            r_issue <= r_issue + ACW'(1);
        end
        r_tag_idx <= r_issue;

        if (r_old_pend) begin
            r_oldq <= $signed(mem_rdata);
        end

        // strict compare keeps the lowest index on ties
        if (r_tag_vld && take) begin
            r_best_val <= $signed(mem_rdata);
            r_best_idx <= r_tag_idx;
        end

        if (r_state == S_CALC && upd_rsp.done) begin
            r_new <= upd_rsp.value;
            r_sat <= upd_rsp.sat;
        end

        if (r_state == S_DONE && out_free) begin
            r_out_action   <= ACTION_IDX_W'(s_act);
            r_out_explored <= r_op && explore_now;
            r_out_value    <= r_op ? r_new : '0;
            r_out_sat      <= r_op && r_sat;
        end
    end

    // ---------------------------------------------------------------- Q table
    // The write in S_WRITE commits before the second sweep issues its first read,
    // so the re-sweep sees the new value without forwarding.
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pidx;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : r_new;
    assign mem_raddr = (r_state == S_OLD) ? r_pidx : (r_row_base + AW'(r_issue));

    qls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_qtab (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- update unit
    assign upd_req.start  = r_upd_start;
    assign upd_req.alpha  = r_learn_rate;
    assign upd_req.gamma  = r_discount;
    assign upd_req.reward = r_reward;
    assign upd_req.maxq   = r_best_val;
    assign upd_req.oldq   = r_oldq;

    qls_update u_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (upd_req),
        .o_rsp   (upd_rsp)
    );

    // ---------------------------------------------------------------- outputs
    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_out_action;
    assign o_explored      = r_out_explored;
    assign o_updated_value = r_out_value;
    assign o_saturated     = r_out_sat;

`ifndef SYNTH
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_rsp.done |-> (r_state == S_CALC))
        else $error("update result outside the calc phase");

    a_tag_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_vld |-> (r_state == S_ROW1 || r_state == S_ROW2))
        else $error("row read data outside a sweep");

    a_write_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_ROW2 || r_state == S_DONE))
        else $error("bad state after table write");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_updated_value == {1'b0, {(VALUE_W-1){1'b1}}} ||
             o_updated_value == {1'b1, {(VALUE_W-1){1'b0}}}))
        else $error("saturated result not at a range limit");
`endif

endmodule

/* dv/tabular_q_learning_step_core_tb.sv */
// Self-checking testbench of the tabular Q-learning step core.
module tabular_q_learning_step_core_tb
    import qls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // item opcodes and the one register index the core does not decode
    localparam logic             OP_START   = 1'b0;
    localparam logic             OP_LEARN   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int NUM_Q = NUM_STATES_DEF * NUM_ACTIONS_DEF;

    localparam logic signed [VALUE_W-1:0] R_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] R_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] R_ONE = 32'sh0001_0000;

    localparam longint V_MAX = 64'sd2147483647;
    localparam longint V_MIN = -64'sd2147483648;

    localparam int TAIL_CYCLES = 64;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int NUM_PHASES = 8;

    // reward mix of a random phase: balanced, or pushed to one rail to drive
    // table rows toward saturation
    typedef enum int unsigned {REW_MIXED, REW_LOW, REW_HIGH} t_reward_mix;

    typedef struct packed {
        logic [ACTION_IDX_W-1:0]   chosen_action;
        logic                      explored;
        logic signed [VALUE_W-1:0] updated_value;
        logic                      saturated;
    } t_q_result;

    // Shadow copy of the Q table, the previous pair and the coefficients.
    // Each accepted item is stepped through it; the expected result is queued.
    class q_step_scoreboard;
        longint                  q_vals [NUM_Q];
        logic [STATE_IDX_W-1:0]  last_state;
        logic [ACTION_IDX_W-1:0] last_action;
        logic [FRAC_W-1:0]       alpha;
        logic [FRAC_W-1:0]       gamma;
        logic [FRAC_W-1:0]       epsilon;
        t_q_result               pending_results [$];
        int unsigned             mismatches;

        function new();
            foreach (q_vals[i]) q_vals[i] = 0;
            last_state  = '0;
            last_action = '0;
            alpha       = LEARN_RATE_RST;
            gamma       = DISCOUNT_RST;
            epsilon     = EXPLORE_PROB_RST;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] data);
            case (idx)
                CFG_LEARN_RATE:   alpha   = data;
                CFG_DISCOUNT:     gamma   = data;
                CFG_EXPLORE_PROB: epsilon = data;
                default: ;
            endcase
        endfunction

        // lowest index wins a tie
        function int unsigned best_action(int unsigned row);
            int unsigned best;
            best = 0;
            for (int unsigned b = 1; b < NUM_ACTIONS_DEF; b++)
                if (q_vals[row*NUM_ACTIONS_DEF + b] > q_vals[row*NUM_ACTIONS_DEF + best])
                    best = b;
            return best;
        endfunction

        function void note_item(logic op, logic [STATE_IDX_W-1:0] s,
                                logic [ACTION_IDX_W-1:0] sa, logic signed [VALUE_W-1:0] r,
                                logic [FRAC_W-1:0] rf, logic [ACTION_IDX_W-1:0] ra);
            t_q_result   want;
            longint      rew;
            longint      maxq;
            longint      oldq;
            longint      diff;
            longint      newq;
            int unsigned slot;
            int unsigned act;
            want = '0;
            if (op == OP_START) begin
                last_state         = s;
                last_action        = sa;
                want.chosen_action = sa;
                pending_results.push_back(want);
                return;
            end
            rew  = r;
            maxq = q_vals[int'(s)*NUM_ACTIONS_DEF + best_action(s)];
            slot = int'(last_state)*NUM_ACTIONS_DEF + int'(last_action);
            oldq = q_vals[slot];
            // arithmetic shift of a signed 64-bit product is the floor division
            diff = rew + ((longint'(gamma) * maxq) >>> FRAC_W) - oldq;
            newq = oldq + ((longint'(alpha) * diff) >>> FRAC_W);
            if (newq > V_MAX) begin
                newq = V_MAX;
                want.saturated = 1'b1;
            end else if (newq < V_MIN) begin
                newq = V_MIN;
                want.saturated = 1'b1;
            end
            q_vals[slot] = newq;
            // argmax after the write: matters when s is the previous state
            act = best_action(s);
            if (epsilon != 0 && rf < epsilon) begin
                act = ra;
                want.explored = 1'b1;
            end
            last_state          = s;
            last_action         = act[ACTION_IDX_W-1:0];
            want.chosen_action  = act[ACTION_IDX_W-1:0];
            want.updated_value  = newq[VALUE_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(t_q_result got);
            t_q_result want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.chosen_action !== want.chosen_action) begin
                $error("chosen_action: expected %0d, got %0d",
                       want.chosen_action, got.chosen_action);
                mismatches++;
            end
            if (got.explored !== want.explored) begin
                $error("explored: expected %0d, got %0d", want.explored, got.explored);
                mismatches++;
            end
            if (got.updated_value !== want.updated_value) begin
                $error("updated_value: expected %0d, got %0d",
                       want.updated_value, got.updated_value);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_op;
    logic [STATE_IDX_W-1:0]    i_state_index;
    logic [ACTION_IDX_W-1:0]   i_start_action;
    logic signed [VALUE_W-1:0] i_reward;
    logic [FRAC_W-1:0]         i_rand_fraction;
    logic [ACTION_IDX_W-1:0]   i_rand_action;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [ACTION_IDX_W-1:0]   o_chosen_action;
    logic                      o_explored;
    logic signed [VALUE_W-1:0] o_updated_value;
    logic                      o_saturated;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [FRAC_W-1:0]         i_cfg_data;

    q_step_scoreboard sb;
    bit               in_calm;   // sender sends back to back
    bit               out_calm;  // receiver never stalls

    tabular_q_learning_step_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_state_index   (i_state_index),
        .i_start_action  (i_start_action),
        .i_reward        (i_reward),
        .i_rand_fraction (i_rand_fraction),
        .i_rand_action   (i_rand_action),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chosen_action (o_chosen_action),
        .o_explored      (o_explored),
        .o_updated_value (o_updated_value),
        .o_saturated     (o_saturated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (table clear, ~620 items with maximal gaps and
    // stalls) is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned idle_cycles(bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // Coefficients: the rails are drawn often on purpose
    function automatic logic [FRAC_W-1:0] pick_coef();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    // Mostly a tiny pool of states so rows fill up and the same-state case is common
    function automatic logic [STATE_IDX_W-1:0] pick_state();
        if ($urandom_range(0, 2) == 0)
            return STATE_IDX_W'($urandom);
        return STATE_IDX_W'($urandom_range(0, 3));
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_reward(t_reward_mix mix);
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (mix == REW_LOW && roll < 5)
            return R_MIN;
        if (mix == REW_HIGH && roll < 5)
            return R_MAX;
        case (roll)
            0:       return R_MAX;
            1:       return R_MIN;
            2, 3:    return VALUE_W'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Fraction near the epsilon boundary a good share of the time
    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 3))
            0:       return sb.epsilon - 16'd1;
            1:       return sb.epsilon;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    // Leaves valid high after the accepting edge; the next call lowers it before an
    // idle gap, or wait_idle lowers it, so valid sees one assignment per step.
    task automatic send_item(input logic op, input logic [STATE_IDX_W-1:0] s,
                             input logic [ACTION_IDX_W-1:0] sa,
                             input logic signed [VALUE_W-1:0] r,
                             input logic [FRAC_W-1:0] rf,
                             input logic [ACTION_IDX_W-1:0] ra);
        int unsigned gap;
        gap = idle_cycles(in_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_state_index   <= s;
        i_start_action  <= sa;
        i_reward        <= r;
        i_rand_fraction <= rf;
        i_rand_action   <= ra;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_item(op, s, sa, r, rf, ra);
    endtask

    // Sender holds off until every expected result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FRAC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // Only called with the core idle
    task automatic set_regs(input logic [FRAC_W-1:0] a, input logic [FRAC_W-1:0] g,
                            input logic [FRAC_W-1:0] e, input bit poke_unused);
        cfg_write(CFG_LEARN_RATE, a);
        cfg_write(CFG_DISCOUNT, g);
        cfg_write(CFG_EXPLORE_PROB, e);
        if (poke_unused)
            cfg_write(CFG_UNUSED, FRAC_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Episodes: a start then a run of learns with random content; one item in
    // ten is pure noise (random op and fields, may interrupt an episode).
    task automatic run_episodes(input int unsigned count, input t_reward_mix mix);
        int unsigned left;
        left = 0;
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom), STATE_IDX_W'($urandom), ACTION_IDX_W'($urandom),
                          VALUE_W'($urandom), FRAC_W'($urandom), ACTION_IDX_W'($urandom));
            end else if (left == 0) begin
                left = $urandom_range(1, 12);
                send_item(OP_START, pick_state(), ACTION_IDX_W'($urandom), pick_reward(mix),
                          FRAC_W'($urandom), ACTION_IDX_W'($urandom));
            end else begin
                left--;
                send_item(OP_LEARN, pick_state(), ACTION_IDX_W'($urandom), pick_reward(mix),
                          pick_fraction(), ACTION_IDX_W'($urandom));
            end
        end
    endtask

    // Receiver: random stall before each result item, then take it and check
    initial begin
        int unsigned hold;
        t_q_result   got;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            hold = idle_cycles(out_calm);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.chosen_action = o_chosen_action;
            got.explored      = o_explored;
            got.updated_value = o_updated_value;
            got.saturated     = o_saturated;
            sb.check_result(got);
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_op            <= OP_START;
        i_state_index   <= '0;
        i_start_action  <= '0;
        i_reward        <= '0;
        i_rand_fraction <= '0;
        i_rand_action   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_LEARN_RATE;
        i_cfg_data      <= '0;
        sb       = new();
        in_calm  = 1'b0;
        out_calm = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset coefficients (epsilon 6554) ---
        // learn before any start: previous pair is (0, 0); the first item also
        // waits out the table clear
        send_item(OP_LEARN, 8'd9, 3'd0, R_ONE, 16'hFFFF, 3'd0);
        send_item(OP_START, 8'd255, 3'd7, R_MIN, 16'h0000, 3'd7);
        // same state as previous, fraction one below epsilon: explores
        send_item(OP_LEARN, 8'd255, 3'd0, R_MAX, 16'd6553, 3'd7);
        // fraction equal to epsilon: greedy
        send_item(OP_LEARN, 8'd255, 3'd7, R_MIN, 16'd6554, 3'd5);
        send_item(OP_START, 8'd0, 3'd0, R_MAX, 16'hFFFF, 3'd0);
        send_item(OP_LEARN, 8'd128, 3'd0, -32'sd1, 16'hFFFF, 3'd0);

        // full alpha and gamma, exploration off; undecoded index poked too
        wait_idle();
        set_regs(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
        send_item(OP_START, 8'd0, 3'd0, '0, 16'h0000, 3'd0);
        // rewards at the rail on the same row push the update past the top
        send_item(OP_LEARN, 8'd0, 3'd5, R_MAX, 16'h0000, 3'd3);
        send_item(OP_LEARN, 8'd0, 3'd5, R_MAX, 16'h0000, 3'd3);
        send_item(OP_LEARN, 8'd0, 3'd2, R_MAX, 16'h0000, 3'd3);
        // big positive old value hit by the most negative reward
        send_item(OP_LEARN, 8'd1, 3'd1, R_MIN, 16'h0000, 3'd4);
        send_item(OP_LEARN, 8'd1, 3'd6, R_MIN, 16'h0000, 3'd4);
        send_item(OP_LEARN, 8'd1, 3'd6, R_MIN, 16'h0000, 3'd4);

        // zero alpha and gamma: table frozen; epsilon at full scale
        wait_idle();
        set_regs(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_item(OP_START, 8'd200, 3'd5, '0, 16'h0000, 3'd0);
        send_item(OP_LEARN, 8'd200, 3'd0, R_MAX, 16'hFFFF, 3'd1);
        send_item(OP_LEARN, 8'd201, 3'd0, R_MIN, 16'hFFFE, 3'd6);

        // --- random phases: new coefficients each time, varied idling ---
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            if (phase == 0)
                set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
            else
                set_regs(pick_coef(), pick_coef(), pick_coef(), $urandom_range(0, 3) == 0);
            in_calm  = (phase % 4 == 1) || (phase % 4 == 3);
            out_calm = (phase % 4 == 2) || (phase % 4 == 3);
            run_episodes(ITEMS_PER_PHASE, t_reward_mix'(phase % 3));
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
